FILE: design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pixel mapper pipeline.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset
`define TJ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a condition that must hold whenever the qualifying signal is high
`define TJ_ASSERT_WHEN(lbl, clk, rst_n, qual, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (qual) |-> (cond)) \
        else $error(msg);

`endif

FILE: design/tjpm_pkg.sv
// ---------------------------------------------------------------------------
// Thermal pixel mapper package
// Widths, constants and shared types of the pixel mapper pipeline.
// ---------------------------------------------------------------------------
package tjpm_pkg;

    // Field widths
    localparam int TEMP_W  = 16;
    localparam int GAIN_W  = 24;
    localparam int LEVEL_W = 8;
    localparam int PROD_W  = TEMP_W + GAIN_W;
    localparam int CFG_IDX_W = 8;

    // Scaling constants
    localparam logic [TEMP_W-1:0] TEMP_BIAS = 16'h37C0;
    localparam int GAIN_FRAC_BITS = 20;

    // Register reset values
    localparam logic [TEMP_W-1:0] WINDOW_LOW_RST   = 16'd18762;
    localparam logic [GAIN_W-1:0] DISPLAY_GAIN_RST = 24'd208896;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY_GAIN = 8'd1;

    // Configuration handed to the scaling stages
    typedef struct packed {
        logic [TEMP_W-1:0] window_low;
        logic [GAIN_W-1:0] display_gain;
    } t_cfg;

endpackage

FILE: design/tjpm_scale.sv
// ---------------------------------------------------------------------------
// Thermal pixel scaler
// Three stages: bias and window offset, gain multiply, round and clamp.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tjpm_scale (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [tjpm_pkg::TEMP_W-1:0]       i_raw_temp,
    input  tjpm_pkg::t_cfg                    i_cfg,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [tjpm_pkg::LEVEL_W-1:0]      o_level
);

    logic                              r_v1, r_v2, r_v3;
    logic [tjpm_pkg::TEMP_W-1:0]       r_diff, n_diff;
    logic [tjpm_pkg::PROD_W-1:0]       r_prod, n_prod;
    logic [tjpm_pkg::LEVEL_W-1:0]      r_level, n_level;
    logic                              w_rdy1, w_rdy2, w_rdy3;
    logic [tjpm_pkg::TEMP_W-1:0]       w_temp;
    logic [tjpm_pkg::PROD_W:0]         w_round;
    logic [tjpm_pkg::PROD_W-tjpm_pkg::GAIN_FRAC_BITS:0] w_q;

    // Each stage takes a new beat when empty or when it drains downstream
    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // Bias the pixel and take its distance above the window bottom
    always_comb begin
        w_temp = i_raw_temp + tjpm_pkg::TEMP_BIAS;
        if (w_temp > i_cfg.window_low) begin
            n_diff = w_temp - i_cfg.window_low;
        end else begin
            n_diff = '0;
        end
    end

    // Apply the gain
    assign n_prod = tjpm_pkg::PROD_W'(r_diff) * tjpm_pkg::PROD_W'(i_cfg.display_gain);

    // Round to nearest and saturate to a display byte
    always_comb begin
        w_round = (tjpm_pkg::PROD_W+1)'(r_prod)
                + ((tjpm_pkg::PROD_W+1)'(1) << (tjpm_pkg::GAIN_FRAC_BITS - 1));
        w_q = w_round[tjpm_pkg::PROD_W:tjpm_pkg::GAIN_FRAC_BITS];
        if (w_q > 255) begin
            n_level = '1;
        end else begin
            n_level = w_q[tjpm_pkg::LEVEL_W-1:0];
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // Advance payload with its valid bit
    always_ff @(posedge i_clk) begin
        if (w_rdy1) r_diff  <= n_diff;
        if (w_rdy2) r_prod  <= n_prod;
        if (w_rdy3) r_level <= n_level;
    end

    assign o_valid = r_v3;
    assign o_level = r_level;

    // A pixel at or under the window bottom yields a zero product
    `TJ_ASSERT(a_zero_diff_zero_prod, i_clk, i_rst_n, (r_v1 && w_rdy2 && r_diff == '0) |=> (r_prod == '0), "zero offset gave nonzero product")

endmodule

FILE: design/tjpm_jet.sv
// ---------------------------------------------------------------------------
// Jet colormap stage
// Maps the display byte to jet red, green and blue in one register stage.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tjpm_jet (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [tjpm_pkg::LEVEL_W-1:0]      i_level,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [tjpm_pkg::LEVEL_W-1:0]      o_level,
    output logic [tjpm_pkg::LEVEL_W-1:0]      o_red,
    output logic [tjpm_pkg::LEVEL_W-1:0]      o_green,
    output logic [tjpm_pkg::LEVEL_W-1:0]      o_blue
);

    localparam logic [9:0] CENTER_R = 10'd765;
    localparam logic [9:0] CENTER_G = 10'd510;
    localparam logic [9:0] CENTER_B = 10'd255;
    localparam logic [9:0] PEAK     = 10'd383;

    logic                         r_v4;
    logic [tjpm_pkg::LEVEL_W-1:0] r_level, r_red, r_green, r_blue;
    logic [tjpm_pkg::LEVEL_W-1:0] n_red, n_green, n_blue;
    logic                         w_rdy4;

    // Triangle of height 383 around the channel center, clipped to 0..255
    function automatic logic [7:0] jet_level(input logic [7:0] d, input logic [9:0] center);
        logic [9:0] d4;
        logic [9:0] offs;
        logic [9:0] v;
        d4 = {d, 2'b00};
        offs = (d4 >= center) ? (d4 - center) : (center - d4);
        if (offs >= PEAK) begin
            jet_level = 8'd0;
        end else begin
            v = PEAK - offs;
            jet_level = (v > 10'd255) ? 8'hFF : v[7:0];
        end
    endfunction

    assign n_red   = jet_level(i_level, CENTER_R);
    assign n_green = jet_level(i_level, CENTER_G);
    assign n_blue  = jet_level(i_level, CENTER_B);

    assign w_rdy4  = !r_v4 || i_ready;
    assign o_ready = w_rdy4;

    // Advance valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_rdy4) begin
            r_v4 <= i_valid;
        end
    end

    // Hold colors until the next stage takes them
    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_level <= i_level;
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_v4;
    assign o_level = r_level;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

    // Red and blue peaks lie far apart on the jet ramp
    `TJ_ASSERT_WHEN(a_red_blue_apart, i_clk, i_rst_n, r_v4, !(r_red == 8'hFF && r_blue == 8'hFF), "red and blue both saturated")

endmodule

FILE: design/tjpm_yuv.sv
// ---------------------------------------------------------------------------
// Luma and chroma stages
// Weighted sums of the rounded RGB, then a rounded divide by 1000.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tjpm_yuv (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [tjpm_pkg::LEVEL_W-1:0]      i_level,
    input  logic [tjpm_pkg::LEVEL_W-1:0]      i_red,
    input  logic [tjpm_pkg::LEVEL_W-1:0]      i_green,
    input  logic [tjpm_pkg::LEVEL_W-1:0]      i_blue,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [tjpm_pkg::LEVEL_W-1:0]      o_level,
    output logic [tjpm_pkg::LEVEL_W-1:0]      o_red,
    output logic [tjpm_pkg::LEVEL_W-1:0]      o_green,
    output logic [tjpm_pkg::LEVEL_W-1:0]      o_blue,
    output logic [tjpm_pkg::LEVEL_W-1:0]      o_luma,
    output logic [tjpm_pkg::LEVEL_W-1:0]      o_chroma_u,
    output logic [tjpm_pkg::LEVEL_W-1:0]      o_chroma_v
);

    // BT.601 weights in thousandths, plus half scale offset and rounding term
    localparam int Y_R = 299;
    localparam int Y_G = 587;
    localparam int Y_B = 114;
    localparam int U_R = -169;
    localparam int U_G = -331;
    localparam int U_B = 500;
    localparam int V_R = 500;
    localparam int V_G = -419;
    localparam int V_B = -81;
    localparam int CHROMA_OFS = 127500;
    localparam int ROUND_HALF = 500;
    localparam int SUM_W = 20;
    // floor(x/1000) = (x * ceil(2^29/1000)) >> 29, exact for x below 2^19
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W = SUM_W - 1 + RECIP_SHIFT - 9;
    localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'(536871);

    logic                         r_v5, r_v6;
    logic                         w_rdy5, w_rdy6;
    logic [tjpm_pkg::LEVEL_W-1:0] r_lvl5, r_red5, r_green5, r_blue5;
    logic signed [SUM_W-1:0]      r_sum_y, r_sum_u, r_sum_v;
    logic signed [SUM_W-1:0]      n_sum_y, n_sum_u, n_sum_v;
    logic [tjpm_pkg::LEVEL_W-1:0] r_lvl6, r_red6, r_green6, r_blue6;
    logic [tjpm_pkg::LEVEL_W-1:0] r_luma, r_cu, r_cv;
    logic [tjpm_pkg::LEVEL_W-1:0] n_luma, n_cu, n_cv;

    // Rounded sum over 1000, negative clipped to zero, saturated to a byte
    function automatic logic [7:0] div1000_sat(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-2:0]           x;
        logic [SUM_W-1+RECIP_W-1:0] prod;
        logic [SUM_W-1+RECIP_W-1-RECIP_SHIFT:0] q;
        x = s[SUM_W-1] ? '0 : s[SUM_W-2:0];
        prod = (SUM_W-1+RECIP_W)'(x) * (SUM_W-1+RECIP_W)'(RECIP_1000);
        q = prod[SUM_W-1+RECIP_W-1:RECIP_SHIFT];
        div1000_sat = (q > 255) ? 8'hFF : q[7:0];
    endfunction

    // Form the three weighted sums with the rounding term folded in
    always_comb begin
        int r, g, b;
        r = int'(i_red);
        g = int'(i_green);
        b = int'(i_blue);
        n_sum_y = SUM_W'(Y_R*r + Y_G*g + Y_B*b + ROUND_HALF);
        n_sum_u = SUM_W'(U_R*r + U_G*g + U_B*b + CHROMA_OFS + ROUND_HALF);
        n_sum_v = SUM_W'(V_R*r + V_G*g + V_B*b + CHROMA_OFS + ROUND_HALF);
    end

    assign n_luma = div1000_sat(r_sum_y);
    assign n_cu   = div1000_sat(r_sum_u);
    assign n_cv   = div1000_sat(r_sum_v);

    assign w_rdy6  = !r_v6 || i_ready;
    assign w_rdy5  = !r_v5 || w_rdy6;
    assign o_ready = w_rdy5;

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (w_rdy5) r_v5 <= i_valid;
            if (w_rdy6) r_v6 <= r_v5;
        end
    end

    // Advance payload with its valid bit
    always_ff @(posedge i_clk) begin
        if (w_rdy5) begin
            r_lvl5   <= i_level;
            r_red5   <= i_red;
            r_green5 <= i_green;
            r_blue5  <= i_blue;
            r_sum_y  <= n_sum_y;
            r_sum_u  <= n_sum_u;
            r_sum_v  <= n_sum_v;
        end
        if (w_rdy6) begin
            r_lvl6   <= r_lvl5;
            r_red6   <= r_red5;
            r_green6 <= r_green5;
            r_blue6  <= r_blue5;
            r_luma   <= n_luma;
            r_cu     <= n_cu;
            r_cv     <= n_cv;
        end
    end

    assign o_valid    = r_v6;
    assign o_level    = r_lvl6;
    assign o_red      = r_red6;
    assign o_green    = r_green6;
    assign o_blue     = r_blue6;
    assign o_luma     = r_luma;
    assign o_chroma_u = r_cu;
    assign o_chroma_v = r_cv;

    // All three sums stay non-negative for any jet color
    `TJ_ASSERT_WHEN(a_sums_nonneg, i_clk, i_rst_n, r_v5, !r_sum_y[SUM_W-1] && !r_sum_u[SUM_W-1] && !r_sum_v[SUM_W-1], "negative luma or chroma sum")

endmodule

FILE: design/thermal_jet_pixel_mapper_top.sv
// ---------------------------------------------------------------------------
// Thermal jet pixel mapper
// Raw thermal pixel to display byte, jet RGB, luma and chroma.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake                 Payload
// pixel     in         i_valid / o_stall         i_raw_temp
// result    out        o_valid / i_stall         o_display_level, o_red, o_green,
//                                                o_blue, o_luma, o_chroma_u, o_chroma_v
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One pixel per cycle while o_stall is low; a pixel's result passes through
// the six register stages (offset, gain multiply, round/clamp, jet,
// weighted sums, divide) on its way to the outputs. Reset is synchronous and
// clears the valid bits and loads the register defaults. An output stall
// holds the result register; stages upstream keep filling bubbles until the
// pipeline is full, then o_stall rises.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module thermal_jet_pixel_mapper_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [tjpm_pkg::TEMP_W-1:0]         i_raw_temp,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [tjpm_pkg::LEVEL_W-1:0]        o_display_level,
    output logic [tjpm_pkg::LEVEL_W-1:0]        o_red,
    output logic [tjpm_pkg::LEVEL_W-1:0]        o_green,
    output logic [tjpm_pkg::LEVEL_W-1:0]        o_blue,
    output logic [tjpm_pkg::LEVEL_W-1:0]        o_luma,
    output logic [tjpm_pkg::LEVEL_W-1:0]        o_chroma_u,
    output logic [tjpm_pkg::LEVEL_W-1:0]        o_chroma_v,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [tjpm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tjpm_pkg::GAIN_W-1:0]         i_cfg_data
);

    tjpm_pkg::t_cfg               r_cfg;
    logic                         w_scale_ready, w_scale_valid;
    logic                         w_jet_ready, w_jet_valid;
    logic                         w_yuv_ready;
    logic [tjpm_pkg::LEVEL_W-1:0] w_level_s, w_level_j;
    logic [tjpm_pkg::LEVEL_W-1:0] w_red, w_green, w_blue;

    // Configuration writes always complete
    assign o_cfg_ready = 1'b1;

    // Load registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_low   <= tjpm_pkg::WINDOW_LOW_RST;
            r_cfg.display_gain <= tjpm_pkg::DISPLAY_GAIN_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tjpm_pkg::CFG_WINDOW_LOW: begin
                    r_cfg.window_low <= i_cfg_data[tjpm_pkg::TEMP_W-1:0];
                end
                tjpm_pkg::CFG_DISPLAY_GAIN: begin
                    r_cfg.display_gain <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    tjpm_scale u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (w_scale_ready),
        .i_raw_temp (i_raw_temp),
        .i_cfg      (r_cfg),
        .o_valid    (w_scale_valid),
        .i_ready    (w_jet_ready),
        .o_level    (w_level_s)
    );

    tjpm_jet u_jet (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_scale_valid),
        .o_ready (w_jet_ready),
        .i_level (w_level_s),
        .o_valid (w_jet_valid),
        .i_ready (w_yuv_ready),
        .o_level (w_level_j),
        .o_red   (w_red),
        .o_green (w_green),
        .o_blue  (w_blue)
    );

    tjpm_yuv u_yuv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_jet_valid),
        .o_ready    (w_yuv_ready),
        .i_level    (w_level_j),
        .i_red      (w_red),
        .i_green    (w_green),
        .i_blue     (w_blue),
        .o_valid    (o_valid),
        .i_ready    (!i_stall),
        .o_level    (o_display_level),
        .o_red      (o_red),
        .o_green    (o_green),
        .o_blue     (o_blue),
        .o_luma     (o_luma),
        .o_chroma_u (o_chroma_u),
        .o_chroma_v (o_chroma_v)
    );

    assign o_stall = !w_scale_ready;

    // An empty result register means every stage can move
    `TJ_ASSERT_WHEN(a_no_stall_when_empty, i_clk, i_rst_n, !o_valid, !o_stall, "input stalled with empty output")

endmodule

FILE: dv/thermal_jet_pixel_mapper_top_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Thermal jet pixel mapper testbench
// Streams raw thermal pixels through the mapper under several window and
// gain settings. Every accepted pixel is mapped in the bench to its display
// byte, jet RGB, luma and chroma. Each output beat is compared field by
// field with the oldest mapped pixel. Both sides idle in random bursts, and
// one long output hold-off fills the pipeline.
// ---------------------------------------------------------------------------
module thermal_jet_pixel_mapper_top_tb;

    // Register index that decodes to nothing
    localparam logic [tjpm_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
    localparam logic [tjpm_pkg::CFG_IDX_W-1:0] CFG_IDX_TOP   = 8'hFF;
    localparam int PHASE_ITEMS = 45;

    typedef struct packed {
        logic [tjpm_pkg::LEVEL_W-1:0] display_level;
        logic [tjpm_pkg::LEVEL_W-1:0] red;
        logic [tjpm_pkg::LEVEL_W-1:0] green;
        logic [tjpm_pkg::LEVEL_W-1:0] blue;
        logic [tjpm_pkg::LEVEL_W-1:0] luma;
        logic [tjpm_pkg::LEVEL_W-1:0] chroma_u;
        logic [tjpm_pkg::LEVEL_W-1:0] chroma_v;
    } t_pixel_color;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_valid = 1'b0;
    logic                               o_stall;
    logic [tjpm_pkg::TEMP_W-1:0]        i_raw_temp = '0;
    logic                               o_valid;
    logic                               i_stall = 1'b0;
    logic [tjpm_pkg::LEVEL_W-1:0]       o_display_level;
    logic [tjpm_pkg::LEVEL_W-1:0]       o_red;
    logic [tjpm_pkg::LEVEL_W-1:0]       o_green;
    logic [tjpm_pkg::LEVEL_W-1:0]       o_blue;
    logic [tjpm_pkg::LEVEL_W-1:0]       o_luma;
    logic [tjpm_pkg::LEVEL_W-1:0]       o_chroma_u;
    logic [tjpm_pkg::LEVEL_W-1:0]       o_chroma_v;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [tjpm_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [tjpm_pkg::GAIN_W-1:0]        i_cfg_data = '0;

    // Bench copy of the mapper registers
    logic [tjpm_pkg::TEMP_W-1:0]        mapper_low  = tjpm_pkg::WINDOW_LOW_RST;
    logic [tjpm_pkg::GAIN_W-1:0]        mapper_gain = tjpm_pkg::DISPLAY_GAIN_RST;

    logic [tjpm_pkg::TEMP_W-1:0]        pending_pix[$];
    t_pixel_color                       color_q[$];
    logic                               pix_beat = 1'b0;
    logic                               quiet_mode = 1'b0;
    logic                               long_hold_done = 1'b0;
    int                                 send_gap = 0;
    int                                 hold_left = 0;
    int                                 results_seen = 0;
    int                                 errors = 0;

    string lane_name[7] = '{"chroma_v", "chroma_u", "luma", "blue", "green", "red",
                            "display_level"};

    thermal_jet_pixel_mapper_top DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_raw_temp      (i_raw_temp),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_display_level (o_display_level),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_luma          (o_luma),
        .o_chroma_u      (o_chroma_u),
        .o_chroma_v      (o_chroma_v),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Jet channel: triangle of height 383 around 255*center, clipped to a byte
    function automatic int jet_channel(input int level, input int center);
        int offs;
        int v;
        offs = 4 * level - 255 * center;
        if (offs < 0) offs = -offs;
        v = 383 - offs;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v;
    endfunction

    // Round a weighted sum in thousandths to a byte
    function automatic logic [tjpm_pkg::LEVEL_W-1:0] round_milli(input int s);
        int q;
        if (s < 0) s = 0;
        q = (s + 500) / 1000;
        return (q > 255) ? 8'd255 : tjpm_pkg::LEVEL_W'(q);
    endfunction

    // Map one raw pixel under the current register copy
    function automatic t_pixel_color map_pixel(input logic [tjpm_pkg::TEMP_W-1:0] raw);
        logic [tjpm_pkg::TEMP_W-1:0]   temp;
        logic [tjpm_pkg::TEMP_W-1:0]   diff;
        logic [tjpm_pkg::PROD_W:0]     prod;
        logic [tjpm_pkg::PROD_W:0]     scaled;
        int                            r;
        int                            g;
        int                            b;
        t_pixel_color                  c;
        temp = raw + tjpm_pkg::TEMP_BIAS;
        c.display_level = '0;
        if (temp > mapper_low) begin
            diff = temp - mapper_low;
            prod = (tjpm_pkg::PROD_W+1)'(diff) * (tjpm_pkg::PROD_W+1)'(mapper_gain);
            scaled = (prod + (tjpm_pkg::PROD_W+1)'(1 << (tjpm_pkg::GAIN_FRAC_BITS - 1)))
                     >> tjpm_pkg::GAIN_FRAC_BITS;
            c.display_level = (scaled > 255) ? 8'd255 : scaled[tjpm_pkg::LEVEL_W-1:0];
        end
        r = jet_channel(int'(c.display_level), 3);
        g = jet_channel(int'(c.display_level), 2);
        b = jet_channel(int'(c.display_level), 1);
        c.red      = tjpm_pkg::LEVEL_W'(r);
        c.green    = tjpm_pkg::LEVEL_W'(g);
        c.blue     = tjpm_pkg::LEVEL_W'(b);
        c.luma     = round_milli(299 * r + 587 * g + 114 * b);
        c.chroma_u = round_milli(-169 * r - 331 * g + 500 * b + 127500);
        c.chroma_v = round_milli(500 * r - 419 * g - 81 * b + 127500);
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 40)
            $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Append one raw pixel to the pending list
    task automatic queue_pixel(input logic [tjpm_pkg::TEMP_W-1:0] raw);
        pending_pix = {pending_pix, raw};
    endtask

    // Pixel driver: hold a stalled beat, else idle or offer the next pixel
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !pix_beat) begin
            // hold the stalled beat
        end else begin
            if (i_valid && !quiet_mode && $urandom_range(0, 5) == 0)
                send_gap = $urandom_range(1, 12);
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (pending_pix.size() > 0) begin
                i_valid    <= 1'b1;
                i_raw_temp <= pending_pix.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stall bursts plus one long hold-off
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!long_hold_done && results_seen >= 40) begin
            long_hold_done = 1'b1;
            hold_left = 300;
            i_stall <= 1'b1;
        end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
            hold_left = $urandom_range(1, 12) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Monitor: map accepted pixels, check result beats against the oldest one
    always @(posedge i_clk) begin
        t_pixel_color got;
        t_pixel_color want;
        pix_beat <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall)
            color_q = {color_q, map_pixel(i_raw_temp)};
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            got = '{o_display_level, o_red, o_green, o_blue, o_luma, o_chroma_u, o_chroma_v};
            if (color_q.size() == 0) begin
                report_mismatch("result with no pixel pending", int'(got.display_level), 0);
            end else begin
                want = color_q.pop_front();
                for (int i = 0; i < 7; i++) begin
                    if (got[i*tjpm_pkg::LEVEL_W +: tjpm_pkg::LEVEL_W]
                        !== want[i*tjpm_pkg::LEVEL_W +: tjpm_pkg::LEVEL_W])
                        report_mismatch(lane_name[i],
                                        int'(got[i*tjpm_pkg::LEVEL_W +: tjpm_pkg::LEVEL_W]),
                                        int'(want[i*tjpm_pkg::LEVEL_W +: tjpm_pkg::LEVEL_W]));
                end
            end
        end
    end

    // Register write beat; out-of-range indexes leave the copy alone
    task automatic write_reg(input logic [tjpm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tjpm_pkg::GAIN_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            tjpm_pkg::CFG_WINDOW_LOW:   mapper_low  = data[tjpm_pkg::TEMP_W-1:0];
            tjpm_pkg::CFG_DISPLAY_GAIN: mapper_gain = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for all pixels to be taken and all results to come back
    task automatic drain_pixels();
        while (pending_pix.size() != 0 || i_valid || color_q.size() != 0)
            @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // Random pixels, mostly inside the current window
    task automatic queue_random_pixels(input int count);
        longint span;
        logic [tjpm_pkg::TEMP_W-1:0] temp;
        if (mapper_gain == 0) span = 65535;
        else span = (longint'(255) << tjpm_pkg::GAIN_FRAC_BITS) / mapper_gain + 2;
        if (span > 65535) span = 65535;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 4) == 0) begin
                queue_pixel(tjpm_pkg::TEMP_W'($urandom));
            end else begin
                temp = mapper_low + tjpm_pkg::TEMP_W'($urandom_range(0, int'(span)));
                queue_pixel(temp - tjpm_pkg::TEMP_BIAS);
            end
        end
    endtask

    function automatic logic [tjpm_pkg::GAIN_W-1:0] gain_for_span(input int span);
        longint g;
        g = (longint'(255) << tjpm_pkg::GAIN_FRAC_BITS) / span;
        return (g > 24'hFFFFFF) ? 24'hFFFFFF : tjpm_pkg::GAIN_W'(g);
    endfunction

    initial begin
        logic [tjpm_pkg::TEMP_W-1:0] lvl_list[14];
        lvl_list = '{16'd0, 16'd31, 16'd32, 16'd63, 16'd64, 16'd95, 16'd96, 16'd127,
                     16'd128, 16'd159, 16'd160, 16'd191, 16'd224, 16'd255};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: below, at and above the window, both clamps, bias wrap
        queue_pixel(16'h0000);
        queue_pixel(16'hFFFF);
        queue_pixel(tjpm_pkg::TEMP_W'(tjpm_pkg::WINDOW_LOW_RST - tjpm_pkg::TEMP_BIAS - 1));
        queue_pixel(tjpm_pkg::TEMP_W'(tjpm_pkg::WINDOW_LOW_RST - tjpm_pkg::TEMP_BIAS));
        queue_pixel(tjpm_pkg::TEMP_W'(tjpm_pkg::WINDOW_LOW_RST - tjpm_pkg::TEMP_BIAS + 1));
        queue_pixel(tjpm_pkg::TEMP_W'(tjpm_pkg::WINDOW_LOW_RST - tjpm_pkg::TEMP_BIAS + 1280));
        queue_pixel(tjpm_pkg::TEMP_W'(tjpm_pkg::WINDOW_LOW_RST - tjpm_pkg::TEMP_BIAS + 1290));
        queue_pixel(16'hC840);
        queue_pixel(16'hC83F);
        drain_pixels();

        // Unity gain with the window on the bias: walk the jet breakpoints.
        // Junk in the upper data bits of the window write must be dropped.
        write_reg(tjpm_pkg::CFG_WINDOW_LOW, {8'h5A, tjpm_pkg::TEMP_BIAS});
        write_reg(tjpm_pkg::CFG_DISPLAY_GAIN, 24'h100000);
        foreach (lvl_list[i]) queue_pixel(lvl_list[i]);
        drain_pixels();

        // Half gain: odd offsets land exactly on a rounding tie
        write_reg(tjpm_pkg::CFG_DISPLAY_GAIN, 24'h080000);
        queue_pixel(16'd1);
        queue_pixel(16'd3);
        drain_pixels();

        // Writes to unused indexes must not disturb the registers
        write_reg(CFG_IDX_SPARE, 24'hFFFFFF);
        write_reg(CFG_IDX_TOP, 24'h000000);

        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: begin
                    write_reg(tjpm_pkg::CFG_WINDOW_LOW,
                              tjpm_pkg::GAIN_W'(tjpm_pkg::WINDOW_LOW_RST));
                    write_reg(tjpm_pkg::CFG_DISPLAY_GAIN, tjpm_pkg::DISPLAY_GAIN_RST);
                end
                1: begin
                    write_reg(tjpm_pkg::CFG_WINDOW_LOW, tjpm_pkg::GAIN_W'($urandom));
                    write_reg(tjpm_pkg::CFG_DISPLAY_GAIN, 24'h000000);
                end
                2: begin
                    write_reg(tjpm_pkg::CFG_WINDOW_LOW, 24'h00FFFF);
                    write_reg(tjpm_pkg::CFG_DISPLAY_GAIN, 24'hFFFFFF);
                end
                3: begin
                    write_reg(tjpm_pkg::CFG_WINDOW_LOW, 24'h000000);
                    write_reg(tjpm_pkg::CFG_DISPLAY_GAIN, 24'hFFFFFF);
                end
                4: begin
                    write_reg(tjpm_pkg::CFG_WINDOW_LOW, 24'h000000);
                    write_reg(tjpm_pkg::CFG_DISPLAY_GAIN, 24'h000001);
                end
                5, 8: begin
                    write_reg(tjpm_pkg::CFG_WINDOW_LOW, tjpm_pkg::GAIN_W'($urandom));
                    write_reg(tjpm_pkg::CFG_DISPLAY_GAIN,
                              gain_for_span($urandom_range(1, 4000)));
                end
                default: begin
                    write_reg(tjpm_pkg::CFG_WINDOW_LOW, tjpm_pkg::GAIN_W'($urandom));
                    write_reg(tjpm_pkg::CFG_DISPLAY_GAIN, tjpm_pkg::GAIN_W'($urandom));
                end
            endcase
            // Run the last setting with both sides at full rate
            if (ph == 8) quiet_mode = 1'b1;
            queue_random_pixels(PHASE_ITEMS);
            drain_pixels();
        end

        repeat (20) @(posedge i_clk);
        if (color_q.size() != 0)
            report_mismatch("results never delivered", 0, color_q.size());
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
